>>> hw/rtl/psd_pkg.sv
package psd_pkg;

	// Default saturation width of the image dimensions.
	localparam int DimBitsDef = 16;

	// Depth of the queue between the parser and the scaler.
	localparam int QDepth = 4;
	localparam int QPtrW = $clog2(QDepth);

	// Accepted magic range, "P1" to "P6".
	localparam logic [15:0] MagicLow = 16'h5031;
	localparam logic [15:0] MagicHigh = 16'h5036;

	// Full level of an 8-bit channel.
	localparam logic [7:0] LevelMax = 8'd255;

	typedef enum logic [2:0] {
		ST_PIXEL,
		ST_MAGIC,
		ST_DIGIT,
		ST_MAXVAL,
		ST_TRUNC
	} psd_status_t;

	typedef enum logic [3:0] {
		PH_MAG1,
		PH_MAG2,
		PH_SKIP,
		PH_HDR,
		PH_WIDTH,
		PH_GAP_H,
		PH_HEIGHT,
		PH_GAP_M,
		PH_MAXV,
		PH_GAP_R,
		PH_RASTER,
		PH_HALT
	} psd_phase_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_EXEC,
		F_BITS,
		F_FLUSH,
		F_DONE
	} psd_fstate_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_DIV,
		B_OUT
	} psd_bstate_t;

	// One result on its way to the scaler. Levels are raw samples when scale is set.
	typedef struct packed {
		psd_status_t status;
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] lvl_r;
		logic [15:0] lvl_g;
		logic [15:0] lvl_b;
		logic        scale;
		logic [15:0] maxl;
		logic        run_end;
	} psd_entry_t;

endpackage

>>> hw/rtl/pnm_stream_decoder.sv
// Channel   Handshake            Words
// input     in_valid, in_stall   data_byte, last_byte
// output    out_valid, out_stall status, pixel_x, pixel_y, red, green, blue, run_end
//
// After taking a byte the parser runs its phase machine once, or again when a header
// byte is handed on to the next phase, steps through the bits of a bitmap byte, flushes
// at end of file and closes it, with any wait for queue space, before taking the next.
// A scaled pixel passes through eight divider steps in the scaler; an unscaled word or
// error goes straight to its output state. A four-word queue lets parser and scaler run apart.
// Reset is asynchronous and leaves the decoder waiting for the first magic byte.
// in_stall is high from the accepting edge until the byte is closed, which waits for
// queue space; out_stall holds the output register and, through the queue, the parser.
module pnm_stream_decoder #(
	parameter int DIM_BITS = psd_pkg::DimBitsDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [15:0] pixel_x,
	output logic [15:0] pixel_y,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic        run_end
);
	import psd_pkg::*;

	psd_entry_t push_ent;
	psd_entry_t pop_ent;
	logic       push;
	logic       pop;
	logic       q_full;
	logic       q_empty;

	// Parser front end.
	psd_front #(
		.DIM_BITS(DIM_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.push     (push),
		.push_ent (push_ent),
		.q_full   (q_full)
	);

	// Word queue.
	psd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_ent(push_ent),
		.full    (q_full),
		.pop     (pop),
		.pop_ent (pop_ent),
		.empty   (q_empty)
	);

	// Scaler back end.
	psd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_ent    (pop_ent),
		.pop      (pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status   (status),
		.pixel_x  (pixel_x),
		.pixel_y  (pixel_y),
		.red      (red),
		.green    (green),
		.blue     (blue),
		.run_end  (run_end)
	);

endmodule

>>> hw/rtl/psd_queue.sv
module psd_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  psd_pkg::psd_entry_t push_ent,
	output logic                full,
	input  logic                pop,
	output psd_pkg::psd_entry_t pop_ent,
	output logic                empty
);
	import psd_pkg::*;

	psd_entry_t       mem_q [QDepth];
	logic [QPtrW-1:0] wr_q;
	logic [QPtrW-1:0] rd_q;
	logic [QPtrW:0]   cnt_q;

	assign full = (cnt_q == (QPtrW+1)'(QDepth));
	assign empty = (cnt_q == '0);
	assign pop_ent = mem_q[rd_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_ent;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

>>> hw/rtl/psd_front.sv
module psd_front #(
	parameter int DIM_BITS = psd_pkg::DimBitsDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          data_byte,
	input  logic                last_byte,
	output logic                push,
	output psd_pkg::psd_entry_t push_ent,
	input  logic                q_full
);
	import psd_pkg::*;

	localparam logic [DIM_BITS-1:0] DimMax = '1;

	psd_fstate_t         fst_q, fst_d;
	psd_phase_t          phase_q, phase_d;
	logic [2:0]          fmt_q, fmt_d;
	logic [DIM_BITS-1:0] img_w_q, img_w_d;
	logic [DIM_BITS-1:0] img_h_q, img_h_d;
	logic [15:0]         maxl_q, maxl_d;
	logic [15:0]         acc_q, acc_d;
	logic [15:0]         col_q, col_d;
	logic [15:0]         row_q, row_d;
	logic [1:0]          chan_q, chan_d;
	logic [15:0]         rhold_q, rhold_d;
	logic [15:0]         ghold_q, ghold_d;
	logic                in_cmt_q, in_cmt_d;
	logic                dseen_q, dseen_d;
	logic [2:0]          bit_q, bit_d;
	logic [7:0]          byte_q, byte_d;
	logic                last_q, last_d;
	logic                pend_valid_q, pend_valid_d;
	psd_entry_t          pend_q, pend_d;

	logic        new_emit;
	psd_entry_t  new_ent;
	logic        adv;
	logic        start;
	logic        tc_go;
	logic [15:0] tc_val;
	logic        hchk;
	logic [15:0] w16;
	logic [15:0] h16;
	logic [15:0] col_n;
	logic [15:0] row_n;
	logic [7:0]  lvl;

	function automatic logic is_ws(input logic [7:0] b);
		return (b == 8'h20) || (b == 8'h09) || (b == 8'h0D) || (b == 8'h0A);
	endfunction

	function automatic logic is_dig(input logic [7:0] b);
		return (b >= 8'h30) && (b <= 8'h39);
	endfunction

	function automatic logic [15:0] inc_sat(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	// Decimal accumulate with saturation; times ten is two shifts.
	function automatic logic [15:0] accum(input logic [15:0] v, input logic [7:0] b,
			input logic [15:0] cap);
		logic [19:0] t;
		t = ({4'd0, v} << 3) + ({4'd0, v} << 1) + {16'd0, b[3:0]};
		return (t > {4'd0, cap}) ? cap : t[15:0];
	endfunction

	function automatic psd_entry_t mk_ent(input psd_status_t st, input logic [15:0] x,
			input logic [15:0] y, input logic [15:0] r, input logic [15:0] g,
			input logic [15:0] b, input logic scl, input logic [15:0] m);
		psd_entry_t e;
		e.status = st;
		e.x = x;
		e.y = y;
		e.lvl_r = r;
		e.lvl_g = g;
		e.lvl_b = b;
		e.scale = scl;
		e.maxl = m;
		e.run_end = 1'b0;
		return e;
	endfunction

	assign w16 = 16'(img_w_q);
	assign h16 = 16'(img_h_q);
	assign in_stall = (fst_q != F_IDLE);

	// A new word may only be produced when the held word can move on.
	assign adv = !(new_emit && pend_valid_q && q_full);

	// The held word goes out when replaced, or with run_end when the byte is done.
	always_comb begin
		push_ent = pend_q;
		push_ent.run_end = (fst_q == F_DONE);
		push = pend_valid_q && (((fst_q == F_DONE) && !q_full) || (new_emit && !q_full));
	end

	// Byte parser: next state of every register.
	always_comb begin
		fst_d = fst_q;
		phase_d = phase_q;
		fmt_d = fmt_q;
		img_w_d = img_w_q;
		img_h_d = img_h_q;
		maxl_d = maxl_q;
		acc_d = acc_q;
		col_d = col_q;
		row_d = row_q;
		chan_d = chan_q;
		rhold_d = rhold_q;
		ghold_d = ghold_q;
		in_cmt_d = in_cmt_q;
		dseen_d = dseen_q;
		bit_d = bit_q;
		byte_d = byte_q;
		last_d = last_q;
		pend_valid_d = pend_valid_q;
		new_emit = 1'b0;
		new_ent = '0;
		start = 1'b0;
		tc_go = 1'b0;
		tc_val = '0;
		hchk = 1'b0;
		col_n = col_q;
		row_n = row_q;
		lvl = '0;

		unique case (fst_q)
			F_IDLE: begin
				if (in_valid) begin
					byte_d = data_byte;
					last_d = last_byte;
					fst_d = F_EXEC;
				end
			end
			F_EXEC: begin
				fst_d = last_q ? F_FLUSH : F_DONE;
				unique case (phase_q)
					PH_MAG1: begin
						acc_d = {8'd0, byte_q};
						phase_d = PH_MAG2;
					end
					PH_MAG2: begin
						acc_d = '0;
						if ({acc_q[7:0], byte_q} >= MagicLow &&
								{acc_q[7:0], byte_q} <= MagicHigh) begin
							fmt_d = byte_q[2:0];
							phase_d = PH_SKIP;
						end else begin
							new_emit = 1'b1;
							new_ent = mk_ent(ST_MAGIC, '0, '0, '0, '0, '0, 1'b0, '0);
							phase_d = PH_HALT;
						end
					end
					PH_SKIP: begin
						phase_d = PH_HDR;
					end
					PH_HDR: begin
						if (in_cmt_q) begin
							if (byte_q == 8'h0A) begin
								in_cmt_d = 1'b0;
							end
						end else if (byte_q == 8'h23) begin
							in_cmt_d = 1'b1;
						end else begin
							phase_d = PH_WIDTH;
							fst_d = F_EXEC;
						end
					end
					PH_WIDTH: begin
						if (is_dig(byte_q)) begin
							img_w_d = DIM_BITS'(accum(w16, byte_q, 16'(DimMax)));
						end else if (is_ws(byte_q)) begin
							phase_d = PH_GAP_H;
						end else begin
							new_emit = 1'b1;
							new_ent = mk_ent(ST_DIGIT, '0, '0, '0, '0, '0, 1'b0, '0);
							phase_d = PH_HALT;
						end
					end
					PH_GAP_H: begin
						if (!is_ws(byte_q)) begin
							phase_d = PH_HEIGHT;
							fst_d = F_EXEC;
						end
					end
					PH_HEIGHT: begin
						if (is_dig(byte_q)) begin
							img_h_d = DIM_BITS'(accum(h16, byte_q, 16'(DimMax)));
						end else if (is_ws(byte_q)) begin
							if (fmt_q == 3'd1) begin
								phase_d = PH_GAP_R;
							end else if (fmt_q == 3'd4) begin
								start = 1'b1;
							end else begin
								phase_d = PH_GAP_M;
							end
						end else begin
							new_emit = 1'b1;
							new_ent = mk_ent(ST_DIGIT, '0, '0, '0, '0, '0, 1'b0, '0);
							phase_d = PH_HALT;
						end
					end
					PH_GAP_M: begin
						if (!is_ws(byte_q)) begin
							phase_d = PH_MAXV;
							fst_d = F_EXEC;
						end
					end
					PH_MAXV: begin
						if (is_dig(byte_q)) begin
							maxl_d = accum(maxl_q, byte_q, 16'hFFFF);
						end else if (is_ws(byte_q)) begin
							if (fmt_q == 3'd2 || fmt_q == 3'd3) begin
								phase_d = PH_GAP_R;
							end else if (maxl_q == '0 || maxl_q > 16'(LevelMax)) begin
								new_emit = 1'b1;
								new_ent = mk_ent(ST_MAXVAL, '0, '0, '0, '0, '0, 1'b0, '0);
								phase_d = PH_HALT;
							end else begin
								start = 1'b1;
							end
						end else begin
							new_emit = 1'b1;
							new_ent = mk_ent(ST_DIGIT, '0, '0, '0, '0, '0, 1'b0, '0);
							phase_d = PH_HALT;
						end
					end
					PH_GAP_R: begin
						if (!is_ws(byte_q)) begin
							start = 1'b1;
							fst_d = F_EXEC;
						end
					end
					PH_RASTER: begin
						unique case (fmt_q)
							3'd1: begin
								if (byte_q == 8'h0A) begin
									row_d = inc_sat(row_q);
									col_d = '0;
								end else if (is_dig(byte_q)) begin
									lvl = (byte_q == 8'h30) ? 8'd0 : LevelMax;
									new_emit = (col_q < w16) && (row_q < h16);
									new_ent = mk_ent(ST_PIXEL, col_q, row_q, 16'(lvl),
										16'(lvl), 16'(lvl), 1'b0, maxl_q);
									col_d = inc_sat(col_q);
								end
							end
							3'd2, 3'd3: begin
								if (is_dig(byte_q)) begin
									acc_d = accum(acc_q, byte_q, 16'hFFFF);
									dseen_d = 1'b1;
								end else if (is_ws(byte_q)) begin
									if (dseen_q) begin
										acc_d = '0;
										dseen_d = 1'b0;
										if (fmt_q == 3'd2) begin
											new_emit = (col_q < w16) && (row_q < h16);
											new_ent = mk_ent(ST_PIXEL, col_q, row_q, acc_q,
												acc_q, acc_q, 1'b1, maxl_q);
											col_d = inc_sat(col_q);
										end else begin
											tc_go = 1'b1;
											tc_val = acc_q;
										end
									end
									if (fmt_q == 3'd2 && byte_q == 8'h0A) begin
										row_d = inc_sat(row_q);
										col_d = '0;
									end
								end
							end
							3'd4: begin
								fst_d = F_BITS;
								bit_d = '0;
							end
							3'd5: begin
								new_emit = (col_q < w16) && (row_q < h16);
								new_ent = mk_ent(ST_PIXEL, col_q, row_q, 16'(byte_q),
									16'(byte_q), 16'(byte_q), 1'b1, maxl_q);
								col_n = inc_sat(col_q);
								if (col_n >= w16) begin
									col_d = '0;
									row_d = inc_sat(row_q);
								end else begin
									col_d = col_n;
								end
								hchk = 1'b1;
							end
							default: begin
								tc_go = 1'b1;
								tc_val = 16'(byte_q);
								hchk = 1'b1;
							end
						endcase
					end
					default: begin
					end
				endcase

				// Colour samples gather in threes before a pixel is formed.
				if (tc_go) begin
					unique case (chan_q)
						2'd0: begin
							rhold_d = tc_val;
							chan_d = 2'd1;
						end
						2'd1: begin
							ghold_d = tc_val;
							chan_d = 2'd2;
						end
						default: begin
							new_emit = (col_q < w16) && (row_q < h16);
							new_ent = mk_ent(ST_PIXEL, col_q, row_q, rhold_q, ghold_q,
								tc_val, 1'b1, maxl_q);
							chan_d = 2'd0;
							col_n = inc_sat(col_q);
							if (col_n >= w16) begin
								col_d = '0;
								row_d = inc_sat(row_q);
							end else begin
								col_d = col_n;
							end
						end
					endcase
				end

				// A binary raster stops once every row is filled.
				if (hchk && row_d >= h16) begin
					phase_d = PH_HALT;
				end

				// Raster start clears the position and sample state; a binary raster with a zero dimension halts.
				if (start) begin
					col_d = '0;
					row_d = '0;
					chan_d = '0;
					acc_d = '0;
					dseen_d = 1'b0;
					if (fmt_q >= 3'd4 && (img_w_q == '0 || img_h_q == '0)) begin
						phase_d = PH_HALT;
					end else begin
						phase_d = PH_RASTER;
					end
				end
			end
			F_BITS: begin
				// One bitmap bit per cycle unless a held word waits for queue space, most significant first.
				if (col_q < w16) begin
					lvl = byte_q[3'd7 - bit_q] ? LevelMax : 8'd0;
					new_emit = (row_q < h16);
					new_ent = mk_ent(ST_PIXEL, col_q, row_q, 16'(lvl), 16'(lvl),
						16'(lvl), 1'b0, maxl_q);
					col_n = col_q + 16'd1;
				end
				col_d = col_n;
				if (bit_q == 3'd7) begin
					if (col_n >= w16) begin
						col_d = '0;
						row_n = inc_sat(row_q);
					end
					row_d = row_n;
					if (row_n >= h16) begin
						phase_d = PH_HALT;
					end
					fst_d = last_q ? F_FLUSH : F_DONE;
				end else begin
					bit_d = bit_q + 3'd1;
				end
			end
			F_FLUSH: begin
				// End of file: flush a pending sample, flag a short binary raster, then clear.
				if (phase_q == PH_RASTER && (fmt_q == 3'd2 || fmt_q == 3'd3) && dseen_q) begin
					if (fmt_q == 3'd2) begin
						new_emit = (col_q < w16) && (row_q < h16);
						new_ent = mk_ent(ST_PIXEL, col_q, row_q, acc_q, acc_q, acc_q,
							1'b1, maxl_q);
					end else if (chan_q == 2'd2) begin
						new_emit = (col_q < w16) && (row_q < h16);
						new_ent = mk_ent(ST_PIXEL, col_q, row_q, rhold_q, ghold_q, acc_q,
							1'b1, maxl_q);
					end
				end
				if (phase_q == PH_RASTER && fmt_q >= 3'd4) begin
					new_emit = 1'b1;
					new_ent = mk_ent(ST_TRUNC, '0, '0, '0, '0, '0, 1'b0, '0);
				end
				phase_d = PH_MAG1;
				fmt_d = '0;
				img_w_d = '0;
				img_h_d = '0;
				maxl_d = '0;
				acc_d = '0;
				col_d = '0;
				row_d = '0;
				chan_d = '0;
				rhold_d = '0;
				ghold_d = '0;
				in_cmt_d = 1'b0;
				dseen_d = 1'b0;
				fst_d = F_DONE;
			end
			F_DONE: begin
				if (!pend_valid_q) begin
					fst_d = F_IDLE;
				end else if (!q_full) begin
					pend_valid_d = 1'b0;
					fst_d = F_IDLE;
				end
			end
			default: begin
				fst_d = F_IDLE;
			end
		endcase

		if (new_emit) begin
			pend_valid_d = 1'b1;
		end
	end

	assign pend_d = new_emit ? new_ent : pend_q;

	// Held word payload.
	always_ff @(posedge clk) begin
		if (adv) begin
			pend_q <= pend_d;
			byte_q <= byte_d;
			last_q <= last_d;
		end
	end

	// Parser state; nothing moves while a word waits for queue space.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fst_q <= F_IDLE;
			phase_q <= PH_MAG1;
			fmt_q <= '0;
			img_w_q <= '0;
			img_h_q <= '0;
			maxl_q <= '0;
			acc_q <= '0;
			col_q <= '0;
			row_q <= '0;
			chan_q <= '0;
			rhold_q <= '0;
			ghold_q <= '0;
			in_cmt_q <= 1'b0;
			dseen_q <= 1'b0;
			bit_q <= '0;
			pend_valid_q <= 1'b0;
		end else if (adv) begin
			fst_q <= fst_d;
			phase_q <= phase_d;
			fmt_q <= fmt_d;
			img_w_q <= img_w_d;
			img_h_q <= img_h_d;
			maxl_q <= maxl_d;
			acc_q <= acc_d;
			col_q <= col_d;
			row_q <= row_d;
			chan_q <= chan_d;
			rhold_q <= rhold_d;
			ghold_q <= ghold_d;
			in_cmt_q <= in_cmt_d;
			dseen_q <= dseen_d;
			bit_q <= bit_d;
			pend_valid_q <= pend_valid_d;
		end
	end

endmodule

>>> hw/rtl/psd_back.sv
module psd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	input  psd_pkg::psd_entry_t q_ent,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [2:0]          status,
	output logic [15:0]         pixel_x,
	output logic [15:0]         pixel_y,
	output logic [7:0]          red,
	output logic [7:0]          green,
	output logic [7:0]          blue,
	output logic                run_end
);
	import psd_pkg::*;

	psd_bstate_t bst_q, bst_d;
	psd_entry_t  ent_q;
	logic [25:0] rem_q [3];
	logic [7:0]  quo_q [3];
	logic [2:0]  step_q;
	logic        out_valid_q;
	logic [2:0]  status_q;
	logic [15:0] pixel_x_q;
	logic [15:0] pixel_y_q;
	logic [7:0]  red_q;
	logic [7:0]  green_q;
	logic [7:0]  blue_q;
	logic        run_end_q;
	logic [15:0] raw [3];
	logic [15:0] in_raw [3];
	logic [25:0] trial;
	logic        ld;

	// Level out is round(v*255/m), full for nonzero v >= m; unscaled keeps v[7:0].
	function automatic logic [7:0] fin(input logic [15:0] v, input logic [15:0] m,
			input logic [7:0] q, input logic scl);
		logic [7:0] r;
		if (!scl) begin
			r = v[7:0];
		end else if (m == '0) begin
			r = (v != '0) ? LevelMax : 8'd0;
		end else if (v >= m) begin
			r = LevelMax;
		end else begin
			r = q;
		end
		return r;
	endfunction

	assign raw[0] = ent_q.lvl_r;
	assign raw[1] = ent_q.lvl_g;
	assign raw[2] = ent_q.lvl_b;
	assign in_raw[0] = q_ent.lvl_r;
	assign in_raw[1] = q_ent.lvl_g;
	assign in_raw[2] = q_ent.lvl_b;

	assign pop = (bst_q == B_IDLE) && !q_empty;
	assign ld = (bst_q == B_OUT) && (!out_valid_q || !out_stall);
	assign trial = 26'({ent_q.maxl, 1'b0}) << step_q;

	// Sequencer: take a word, divide if it needs scaling, hand it to the output.
	always_comb begin
		bst_d = bst_q;
		unique case (bst_q)
			B_IDLE: begin
				if (!q_empty) begin
					bst_d = q_ent.scale ? B_DIV : B_OUT;
				end
			end
			B_DIV: begin
				if (step_q == '0) begin
					bst_d = B_OUT;
				end
			end
			B_OUT: begin
				if (ld) begin
					bst_d = B_IDLE;
				end
			end
			default: begin
				bst_d = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bst_q <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			bst_q <= bst_d;
			if (ld) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Three restoring dividers, one quotient bit per cycle, numerator 510v+m over 2m.
	always_ff @(posedge clk) begin
		if (pop) begin
			ent_q <= q_ent;
			step_q <= 3'd7;
			for (int l = 0; l < 3; l++) begin
				rem_q[l] <= (26'(in_raw[l]) << 9) - (26'(in_raw[l]) << 1) + 26'(q_ent.maxl);
				quo_q[l] <= '0;
			end
		end else if (bst_q == B_DIV) begin
			step_q <= step_q - 3'd1;
			for (int l = 0; l < 3; l++) begin
				if (rem_q[l] >= trial) begin
					rem_q[l] <= rem_q[l] - trial;
					quo_q[l][step_q] <= 1'b1;
				end
			end
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (ld) begin
			status_q <= ent_q.status;
			pixel_x_q <= ent_q.x;
			pixel_y_q <= ent_q.y;
			red_q <= fin(raw[0], ent_q.maxl, quo_q[0], ent_q.scale);
			green_q <= fin(raw[1], ent_q.maxl, quo_q[1], ent_q.scale);
			blue_q <= fin(raw[2], ent_q.maxl, quo_q[2], ent_q.scale);
			run_end_q <= ent_q.run_end;
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign pixel_x = pixel_x_q;
	assign pixel_y = pixel_y_q;
	assign red = red_q;
	assign green = green_q;
	assign blue = blue_q;
	assign run_end = run_end_q;

endmodule
